// ===== src/lqcg_pkg.sv =====
// Package for the lidar quadrant collision gate.
// Holds field widths, sector and register codes, the result entry type and the gating function.
// No dependencies.
package lqcg_pkg;

  localparam int RangeW = 16;
  localparam int VelW   = 16;
  localparam int AngW   = 16;
  localparam int NumSec = 4;

  localparam logic signed [AngW-1:0] AngEighth      = 16'sd8192;
  localparam logic signed [AngW-1:0] AngThreeEighth = 16'sd24576;
  localparam logic [RangeW-1:0]      NoRange        = 16'hFFFF;

  // Sector codes, which are also the flag bit positions.
  typedef enum logic [1:0] {
    SEC_FRONT = 2'd0,
    SEC_RIGHT = 2'd1,
    SEC_BACK  = 2'd2,
    SEC_LEFT  = 2'd3
  } sector_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SCAN_START  = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_MIN_RANGE   = 3'd2,
    REG_MAX_RANGE   = 3'd3,
    REG_COLL_DIST   = 3'd4
  } reg_idx_t;

  // Input action codes.
  typedef enum logic {
    ACT_SAMPLE  = 1'b0,
    ACT_COMMAND = 1'b1
  } action_t;

  // Result kind codes.
  typedef enum logic {
    KIND_COMMAND = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [VelW-1:0] x;
    logic signed [VelW-1:0] y;
    logic                   hit;
  } gated_t;

  // One queued job: a gated command, optionally followed by a status result.
  typedef struct packed {
    logic                          pair;
    logic signed [VelW-1:0]        x;
    logic signed [VelW-1:0]        y;
    logic signed [VelW-1:0]        turn;
    logic                          hit;
    logic [NumSec-1:0]             flags;
    logic [NumSec-1:0][RangeW-1:0] mins;
  } entry_t;

  // Zero each velocity axis that points into a flagged sector.
  function automatic gated_t gate_cmd(input logic signed [VelW-1:0] x,
                                      input logic signed [VelW-1:0] y,
                                      input logic [NumSec-1:0] flags);
    gated_t g;
    logic   kill_x;
    logic   kill_y;
    kill_x = (flags[SEC_FRONT] && (x > 0)) || (flags[SEC_BACK] && (x < 0));
    kill_y = (flags[SEC_LEFT] && (y > 0)) || (flags[SEC_RIGHT] && (y < 0));
    g.x   = kill_x ? '0 : x;
    g.y   = kill_y ? '0 : y;
    g.hit = kill_x || kill_y;
    return g;
  endfunction

endpackage

// ===== src/lidar_quadrant_collision_gate_top.sv =====
// Top level of the lidar quadrant collision gate; depends on lqcg_pkg for types, codes and gating.
// Each job is registered into the two-entry result queue and presented from its head; a status
// result follows its command result one output transfer later. Throughput: one input item per
// cycle while the queue has room; a scan end that raises flags takes two output transfers.
// rst_n is synchronous, active low, and returns all registers, flags, minima and the stored
// command to their reset values; the queue storage itself is not reset.
module lidar_quadrant_collision_gate_top
  import lqcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // range_mm[15:0], vel_x[31:16], vel_y[47:32], turn_rate[63:48]
  input  logic        in_tlast,   // scan_end
  input  logic        in_tuser,   // action
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata, // safe_x[15:0], safe_y[31:16], safe_turn[47:32],
                                  // intervened[48], sector_flags[52:49], front_min[68:53],
                                  // right_min[84:69], back_min[100:85], left_min[116:101],
                                  // zero fill [119:117]
  output logic         out_tlast, // last_of_run
  output logic         out_tuser, // result_kind
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic signed [AngW-1:0] scan_start_r;
  logic signed [AngW-1:0] angle_step_r;
  logic [RangeW-1:0]      min_range_r;
  logic [RangeW-1:0]      max_range_r;
  logic [RangeW-1:0]      coll_dist_r;

  // Scan state.
  logic                          scan_open_r, scan_open_nxt;
  logic signed [AngW-1:0]        angle_r, angle_nxt;
  logic [NumSec-1:0]             wflags_r, wflags_nxt;
  logic [NumSec-1:0][RangeW-1:0] mins_r, mins_nxt;
  logic [NumSec-1:0]             cflags_r, cflags_nxt;
  logic signed [VelW-1:0]        cmd_x_r, cmd_y_r, cmd_turn_r;
  logic signed [VelW-1:0]        cmd_x_nxt, cmd_y_nxt, cmd_turn_nxt;

  // Result queue: two jobs, each one or two results.
  entry_t     q_mem [2];
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       q_wr_r;
  logic       q_rd_r;
  logic       phase_r, phase_nxt;
  entry_t     head;
  entry_t     push_ent;
  logic       push;
  logic       pop;

  logic in_xfer;
  logic out_xfer;

  // Decoded input fields.
  logic                   act;
  logic [RangeW-1:0]      range_mm;
  logic signed [VelW-1:0] vel_x, vel_y, turn_rate;

  // Sample path.
  logic signed [AngW-1:0]        cur_angle;
  logic [NumSec-1:0]             wflags_base;
  logic [NumSec-1:0][RangeW-1:0] mins_base;
  logic                          range_ok;
  sector_t                       sec;
  gated_t                        gate_new;
  gated_t                        gate_old;

  assign act       = in_tuser;
  assign range_mm  = in_tdata[15:0];
  assign vel_x     = in_tdata[31:16];
  assign vel_y     = in_tdata[47:32];
  assign turn_rate = in_tdata[63:48];

  // Config always taken; the user keeps the block idle whenever it is written; not enforced.
  assign cfg_ready = 1'b1;

  // Room is kept for a whole job, so input readiness does not depend on out_tready.
  assign in_tready = (q_cnt_r != 2'd2);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_start_r <= 16'sh8000;
      angle_step_r <= 16'sd182;
      min_range_r  <= 16'd100;
      max_range_r  <= 16'd12000;
      coll_dist_r  <= 16'd600;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCAN_START: scan_start_r <= cfg_data;
        REG_ANGLE_STEP: angle_step_r <= cfg_data;
        REG_MIN_RANGE:  min_range_r  <= cfg_data;
        REG_MAX_RANGE:  max_range_r  <= cfg_data;
        REG_COLL_DIST:  coll_dist_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The first sample of a scan starts from the configured angle with cleared flags and minima.
  assign cur_angle   = scan_open_r ? angle_r : scan_start_r;
  assign wflags_base = scan_open_r ? wflags_r : '0;
  always_comb begin
    for (int i = 0; i < NumSec; i++) begin
      mins_base[i] = scan_open_r ? mins_r[i] : NoRange;
    end
  end

  assign range_ok = (range_mm >= min_range_r) && (range_mm <= max_range_r);

  // Sector boundaries at plus and minus 45 and 135 degrees; wrap of the angle is the
  // normalization.
  always_comb begin
    if ((cur_angle >= -AngEighth) && (cur_angle <= AngEighth)) begin
      sec = SEC_FRONT;
    end else if ((cur_angle > AngEighth) && (cur_angle <= AngThreeEighth)) begin
      sec = SEC_LEFT;
    end else if ((cur_angle > AngThreeEighth) || (cur_angle < -AngThreeEighth)) begin
      sec = SEC_BACK;
    end else begin
      sec = SEC_RIGHT;
    end
  end

  // A new command is gated by the flags of the last completed scan. At a scan end the stored
  // command is gated below by the flags that are being committed.
  assign gate_new = gate_cmd(vel_x, vel_y, cflags_r);

  always_comb begin
    scan_open_nxt = scan_open_r;
    angle_nxt     = angle_r;
    wflags_nxt    = wflags_r;
    mins_nxt      = mins_r;
    cflags_nxt    = cflags_r;
    cmd_x_nxt     = cmd_x_r;
    cmd_y_nxt     = cmd_y_r;
    cmd_turn_nxt  = cmd_turn_r;
    gate_old      = '0;
    push          = 1'b0;
    push_ent      = '0;

    if (in_xfer) begin
      if (act == ACT_COMMAND) begin
        cmd_x_nxt     = vel_x;
        cmd_y_nxt     = vel_y;
        cmd_turn_nxt  = turn_rate;
        push          = 1'b1;
        push_ent.pair = 1'b0;
        push_ent.x    = gate_new.x;
        push_ent.y    = gate_new.y;
        push_ent.turn = turn_rate;
        push_ent.hit  = gate_new.hit;
        push_ent.flags = cflags_r;
      end else begin
        scan_open_nxt = 1'b1;
        angle_nxt     = cur_angle + angle_step_r;
        wflags_nxt    = wflags_base;
        mins_nxt      = mins_base;
        if (range_ok) begin
          if (range_mm < mins_base[sec]) begin
            mins_nxt[sec] = range_mm;
          end
          if (range_mm <= coll_dist_r) begin
            wflags_nxt[sec] = 1'b1;
          end
        end
        if (in_tlast) begin
          scan_open_nxt = 1'b0;
          cflags_nxt    = wflags_nxt;
          gate_old      = gate_cmd(cmd_x_r, cmd_y_r, wflags_nxt);
          // Only a scan that raised a flag produces results.
          if (wflags_nxt != '0) begin
            push           = 1'b1;
            push_ent.pair  = 1'b1;
            push_ent.x     = gate_old.x;
            push_ent.y     = gate_old.y;
            push_ent.turn  = cmd_turn_r;
            push_ent.hit   = gate_old.hit;
            push_ent.flags = wflags_nxt;
            push_ent.mins  = mins_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_open_r <= 1'b0;
      angle_r     <= '0;
      wflags_r    <= '0;
      for (int i = 0; i < NumSec; i++) begin
        mins_r[i] <= NoRange;
      end
      cflags_r    <= '0;
      cmd_x_r     <= '0;
      cmd_y_r     <= '0;
      cmd_turn_r  <= '0;
    end else begin
      scan_open_r <= scan_open_nxt;
      angle_r     <= angle_nxt;
      wflags_r    <= wflags_nxt;
      mins_r      <= mins_nxt;
      cflags_r    <= cflags_nxt;
      cmd_x_r     <= cmd_x_nxt;
      cmd_y_r     <= cmd_y_nxt;
      cmd_turn_r  <= cmd_turn_nxt;
    end
  end

  // Output side. A paired job first shows its command result, then its status result.
  assign head       = q_mem[q_rd_r];
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign pop        = out_xfer && (!head.pair || phase_r);

  always_comb begin
    phase_nxt = phase_r;
    if (out_xfer) begin
      phase_nxt = head.pair && !phase_r;
    end
    q_cnt_nxt = q_cnt_r;
    case ({push, pop})
      2'b10:   q_cnt_nxt = q_cnt_r + 2'd1;
      2'b01:   q_cnt_nxt = q_cnt_r - 2'd1;
      default: q_cnt_nxt = q_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      phase_r <= phase_nxt;
      if (push) begin
        q_wr_r <= !q_wr_r;
      end
      if (pop) begin
        q_rd_r <= !q_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr_r] <= push_ent;
    end
  end

  // Minima appear only in the status result; the command result carries zeros there.
  always_comb begin
    out_tuser = phase_r ? KIND_STATUS : KIND_COMMAND;
    out_tlast = !head.pair || phase_r;
    out_tdata = '0;
    out_tdata[15:0]  = head.x;
    out_tdata[31:16] = head.y;
    out_tdata[47:32] = head.turn;
    out_tdata[48]    = head.hit;
    out_tdata[52:49] = head.flags;
    if (phase_r) begin
      out_tdata[68:53]   = head.mins[SEC_FRONT];
      out_tdata[84:69]   = head.mins[SEC_RIGHT];
      out_tdata[100:85]  = head.mins[SEC_BACK];
      out_tdata[116:101] = head.mins[SEC_LEFT];
    end
  end

  // The queue never holds more than its two entries.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("result queue count out of range");

  // The status phase is only entered for a job that has a status result.
  a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (head.pair && out_tvalid))
    else $error("status phase without a paired job");

  // A velocity command always leaves a result waiting in the next cycle.
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (act == ACT_COMMAND)) |=> out_tvalid)
    else $error("velocity command produced no result");

  // A scan end always closes the scan.
  a_scan_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (act == ACT_SAMPLE) && in_tlast) |=> !scan_open_r)
    else $error("scan still open after its last sample");

endmodule

// ===== tb/sv/lidar_quadrant_collision_gate_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lidar_quadrant_collision_gate_top: directed table, then random scans.
// Depends on lqcg_pkg for codes and types, and on the RTL of the top level.
module lidar_quadrant_collision_gate_top_tb
  import lqcg_pkg::*;
;

  // Longest legal quiet stretch is the deliberate receiver hold-off, so the watchdog sits well
  // above it.
  localparam int         WatchdogLimit = 2000;
  localparam int         LongHold      = 400;
  localparam int         DrainCycles   = 8;
  localparam int         MaxShown      = 10;
  localparam int         PhaseItems    = 128;
  localparam int         DirRows       = 21;
  // An index past the last register; the block must drop this write.
  localparam logic [2:0] RegNone       = 3'd7;

  // One result as it leaves the block, unpacked from tdata, tlast and tuser.
  typedef struct packed {
    kind_t                  kind;
    logic                   last;
    logic signed [VelW-1:0] x;
    logic signed [VelW-1:0] y;
    logic signed [VelW-1:0] turn;
    logic                   hit;
    logic [NumSec-1:0]      flags;
    logic [RangeW-1:0]      fmin;
    logic [RangeW-1:0]      rmin;
    logic [RangeW-1:0]      bmin;
    logic [RangeW-1:0]      lmin;
  } result_t;

  // One input item. Rows of the directed table may carry a hand-written expected command
  // result (typed set); every other item is checked against the predictor alone.
  typedef struct {
    action_t                act;
    logic [RangeW-1:0]      rng;
    logic                   last;
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
    logic signed [VelW-1:0] vt;
    logic                   typed;
    logic signed [VelW-1:0] wx;
    logic signed [VelW-1:0] wy;
    logic                   whit;
    logic [NumSec-1:0]      wflags;
  } row_t;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata   = '0;
  logic         in_tlast   = 1'b0;
  logic         in_tuser   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tlast;
  logic         out_tuser;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index  = '0;
  logic [15:0]  cfg_data   = '0;

  lidar_quadrant_collision_gate_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the configuration registers, at their reset values.
  logic [AngW-1:0]   start_ang = 16'h8000;
  logic [AngW-1:0]   ang_step  = 16'd182;
  logic [RangeW-1:0] min_r     = 16'd100;
  logic [RangeW-1:0] max_r     = 16'd12000;
  logic [RangeW-1:0] coll_d    = 16'd600;

  // Shadow copy of the scan and command state, at its reset values.
  logic                   scan_open  = 1'b0;
  logic [AngW-1:0]        sample_ang = '0;
  logic [NumSec-1:0]      work_flags = '0;
  logic [RangeW-1:0]      sec_min [NumSec] = '{NoRange, NoRange, NoRange, NoRange};
  logic [NumSec-1:0]      comm_flags = '0;
  logic signed [VelW-1:0] cmd_x      = '0;
  logic signed [VelW-1:0] cmd_y      = '0;
  logic signed [VelW-1:0] cmd_turn   = '0;

  result_t gate_results_q [$];  // results still owed by the block, oldest first
  row_t    staged;              // item currently offered on the input channel
  row_t    dir_tab [DirRows];
  int      mismatches     = 0;
  int      quiet_cycles   = 0;
  int      burst_left     = 0;
  bit      offering       = 1'b0;
  bit      long_stall_req = 1'b0;

  // Appends one result to the tail of the owed list.
  function automatic void owe_result(result_t r);
    gate_results_q = {gate_results_q, r};
  endfunction

  // The stored command as the block would send it now: an axis pointing into a flagged
  // sector is forced to zero. The turn rate is never touched.
  function automatic result_t gated_cmd(kind_t kind, logic last);
    result_t r;
    logic    kill_x;
    logic    kill_y;
    kill_x = (comm_flags[SEC_FRONT] && cmd_x > 0) || (comm_flags[SEC_BACK] && cmd_x < 0);
    kill_y = (comm_flags[SEC_LEFT] && cmd_y > 0) || (comm_flags[SEC_RIGHT] && cmd_y < 0);
    r       = '0;
    r.kind  = kind;
    r.last  = last;
    r.x     = kill_x ? '0 : cmd_x;
    r.y     = kill_y ? '0 : cmd_y;
    r.turn  = cmd_turn;
    r.hit   = kill_x || kill_y;
    r.flags = comm_flags;
    return r;
  endfunction

  // Advances the shadow state by one accepted item and returns the results it causes.
  task automatic collision_step(input row_t r, output result_t r0, output result_t r1,
                                output int n);
    logic signed [AngW-1:0] a;
    sector_t                sec;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (r.act == ACT_COMMAND) begin
      cmd_x    = r.vx;
      cmd_y    = r.vy;
      cmd_turn = r.vt;
      r0       = gated_cmd(KIND_COMMAND, 1'b1);
      n        = 1;
    end else begin
      // The first sample after reset or after a scan end opens a fresh scan.
      if (!scan_open) begin
        scan_open  = 1'b1;
        sample_ang = start_ang;
        work_flags = '0;
        foreach (sec_min[i]) sec_min[i] = NoRange;
      end
      a          = sample_ang;
      sample_ang = sample_ang + ang_step;
      // Samples outside the valid window still advance the angle but touch nothing else.
      if (r.rng >= min_r && r.rng <= max_r) begin
        if (a >= -AngEighth && a <= AngEighth) begin
          sec = SEC_FRONT;
        end else if (a > AngEighth && a <= AngThreeEighth) begin
          sec = SEC_LEFT;
        end else if (a > AngThreeEighth || a < -AngThreeEighth) begin
          sec = SEC_BACK;
        end else begin
          sec = SEC_RIGHT;
        end
        if (r.rng < sec_min[sec]) sec_min[sec] = r.rng;
        if (r.rng <= coll_d) work_flags[sec] = 1'b1;
      end
      // A scan end commits the flags even when its own sample was skipped; a clean scan
      // commits silently.
      if (r.last) begin
        scan_open  = 1'b0;
        comm_flags = work_flags;
        if (comm_flags != '0) begin
          r0      = gated_cmd(KIND_COMMAND, 1'b0);
          r1      = gated_cmd(KIND_STATUS, 1'b1);
          r1.fmin = sec_min[SEC_FRONT];
          r1.rmin = sec_min[SEC_RIGHT];
          r1.bmin = sec_min[SEC_BACK];
          r1.lmin = sec_min[SEC_LEFT];
          n       = 2;
        end
      end
    end
  endtask

  function automatic string show(result_t r);
    return {$sformatf("kind=%0d last=%0d x=%0d y=%0d turn=%0d hit=%0d flags=%h",
                      r.kind, r.last, r.x, r.y, r.turn, r.hit, r.flags),
            $sformatf(" min f/r/b/l=%0d/%0d/%0d/%0d", r.fmin, r.rmin, r.bmin, r.lmin)};
  endfunction

  // Every transfer on all three channels is seen here, at the clock edge where it happens.
  // Input transfers feed the predictor, result transfers are checked against the oldest
  // expectation, and configuration transfers update the shadow registers.
  always @(posedge clk) begin : bus_watch
    result_t want;
    result_t extra;
    result_t seen;
    int      n;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end

      if (in_tvalid && in_tready) begin
        collision_step(staged, want, extra, n);
        if (staged.typed) begin
          // Hand-written expectation for a command; the predictor has still moved its state.
          want       = '0;
          want.kind  = KIND_COMMAND;
          want.last  = 1'b1;
          want.x     = staged.wx;
          want.y     = staged.wy;
          want.turn  = staged.vt;
          want.hit   = staged.whit;
          want.flags = staged.wflags;
          owe_result(want);
        end else begin
          if (n > 0) owe_result(want);
          if (n > 1) owe_result(extra);
        end
      end

      if (out_tvalid && out_tready) begin
        seen.kind  = kind_t'(out_tuser);
        seen.last  = out_tlast;
        seen.x     = out_tdata[15:0];
        seen.y     = out_tdata[31:16];
        seen.turn  = out_tdata[47:32];
        seen.hit   = out_tdata[48];
        seen.flags = out_tdata[52:49];
        seen.fmin  = out_tdata[68:53];
        seen.rmin  = out_tdata[84:69];
        seen.bmin  = out_tdata[100:85];
        seen.lmin  = out_tdata[116:101];
        if (gate_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown) $display("ERROR: unexpected result %s", show(seen));
        end else begin
          want = gate_results_q.pop_front();
          if (seen.kind !== want.kind || seen.last !== want.last || seen.x !== want.x ||
              seen.y !== want.y || seen.turn !== want.turn || seen.hit !== want.hit ||
              seen.flags !== want.flags || seen.fmin !== want.fmin ||
              seen.rmin !== want.rmin || seen.bmin !== want.bmin || seen.lmin !== want.lmin) begin
            mismatches++;
            if (mismatches <= MaxShown) begin
              $display("ERROR: result mismatch at %0t", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCAN_START: start_ang = cfg_data;
          REG_ANGLE_STEP: ang_step  = cfg_data;
          REG_MIN_RANGE:  min_r     = cfg_data;
          REG_MAX_RANGE:  max_r     = cfg_data;
          REG_COLL_DIST:  coll_d    = cfg_data;
          default: ;
        endcase
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WatchdogLimit);
    $display("lidar_quadrant_collision_gate_top_tb NOT OK");
    $finish;
  end

  // Result side. Ready follows a pattern that changes from run to run: always ready,
  // coin flip, mostly ready or mostly stalled. On request it holds off for a long stretch so
  // that the block backs up into its input.
  initial begin : result_sink
    int mode;
    int run;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(8, 120);
      repeat (run) begin
        @(posedge clk);
        if (long_stall_req) begin
          long_stall_req = 1'b0;
          out_tready <= 1'b0;
          repeat (LongHold) @(posedge clk);
        end else begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            2:       out_tready <= ($urandom_range(0, 4) != 0);
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  function automatic row_t make_row(action_t act, logic [RangeW-1:0] rng, logic last,
                                    logic [VelW-1:0] vx, logic [VelW-1:0] vy,
                                    logic [VelW-1:0] vt);
    row_t r;
    r.act    = act;
    r.rng    = rng;
    r.last   = last;
    r.vx     = vx;
    r.vy     = vy;
    r.vt     = vt;
    r.typed  = 1'b0;
    r.wx     = '0;
    r.wy     = '0;
    r.whit   = 1'b0;
    r.wflags = '0;
    return r;
  endfunction

  // Ranges cluster around the window edges and the collision distance, with wrap allowed.
  function automatic logic [RangeW-1:0] pick_range();
    case ($urandom_range(0, 9))
      0:       return min_r - 16'd1 - 16'($urandom_range(0, 50));
      1:       return max_r + 16'd1 + 16'($urandom_range(0, 50));
      2:       return min_r;
      3:       return max_r;
      4:       return coll_d;
      5:       return coll_d + 16'd1;
      6:       return 16'($urandom);
      7:       return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: return coll_d + 16'($urandom_range(0, 3000)) - 16'd1500;
    endcase
  endfunction

  function automatic logic [VelW-1:0] pick_vel();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic row_t make_cmd();
    return make_row(ACT_COMMAND, 16'($urandom), 1'($urandom_range(0, 1)),
                    pick_vel(), pick_vel(), pick_vel());
  endfunction

  // Offers one item and returns at the edge where it is transferred. The sender works in
  // bursts; between bursts it may drop valid.
  task automatic push_item(input row_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 && offering) begin
        in_tvalid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {r.vt, r.vy, r.vx, r.rng};
    in_tlast  <= r.last;
    in_tuser  <= r.act;
    staged    <= r;
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering and waits until every owed result has come out, then waits out DrainCycles
  // in case a trailing sample without results is still in flight.
  task automatic settle();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (gate_results_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes all five registers back to back, then one write to an unused index.
  task automatic program_regs(input logic [15:0] st, input logic [15:0] sp,
                              input logic [15:0] mn, input logic [15:0] mx,
                              input logic [15:0] cd);
    logic [2:0]  idx [6];
    logic [15:0] val [6];
    idx = '{REG_SCAN_START, REG_ANGLE_STEP, REG_MIN_RANGE, REG_MAX_RANGE, REG_COLL_DIST, RegNone};
    val = '{st, sp, mn, mx, cd, 16'($urandom)};
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // One random phase under a fixed setting. Most traffic is well-formed scans, mostly short and
  // now and then long enough to sweep a wide arc, with commands dropped in mid-scan; a scan is
  // cut to the items left in the phase. The rest is stray commands and raw noise that ends
  // scans at odd places. A twist of 1 asks the receiver for its long hold-off a third of the
  // way in; a twist of 2 makes the sender wait there until every owed result has arrived.
  task automatic run_phase(input logic [15:0] st, input logic [15:0] sp,
                           input logic [15:0] mn, input logic [15:0] mx,
                           input logic [15:0] cd, input int twist);
    int made;
    int len;
    settle();
    program_regs(st, sp, mn, mx, cd);
    made = 0;
    while (made < PhaseItems) begin
      if (twist != 0 && made >= PhaseItems / 3) begin
        if (twist == 1) long_stall_req = 1'b1;
        else settle();
        twist = 0;
      end
      case ($urandom_range(0, 9))
        0: begin
          push_item(make_row(action_t'($urandom_range(0, 1)), 16'($urandom),
                             1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                             16'($urandom)));
          made++;
        end
        1: begin
          push_item(make_cmd());
          made++;
        end
        default: begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 380) : $urandom_range(1, 24);
          if (len > PhaseItems - made) len = PhaseItems - made;
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
              push_item(make_cmd());
              made++;
            end
            push_item(make_row(ACT_SAMPLE, pick_range(), i == len - 1, 16'($urandom),
                               16'($urandom), 16'($urandom)));
            made++;
          end
        end
      endcase
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset setting. Commands on a clean slate pass through, the
    // first scan is flagged in the back sector, then: a scan that ends with nothing flagged,
    // a scan end on a skipped sample, a command in the middle of a scan, and the collision
    // distance hit exactly and missed by one.
    dir_tab = '{
      '{ACT_COMMAND, 16'd0,     1'b0, 16'sd1000, -16'sd500, 16'sd77,
        1'b1, 16'sd1000, -16'sd500, 1'b0, 4'b0000},
      '{ACT_COMMAND, 16'hFFFF,  1'b1, 16'h7FFF,  16'h7FFF,  16'h8000,
        1'b1, 16'h7FFF,  16'h7FFF,  1'b0, 4'b0000},
      '{ACT_COMMAND, 16'd0,     1'b0, 16'h8000,  16'h8000,  16'h7FFF,
        1'b1, 16'h8000,  16'h8000,  1'b0, 4'b0000},
      '{ACT_SAMPLE,  16'd500,   1'b0, 16'h5A5A,  16'hA5A5,  16'h1234,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_SAMPLE,  16'd99,    1'b0, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_SAMPLE,  16'd12001, 1'b0, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_SAMPLE,  16'd12000, 1'b0, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_SAMPLE,  16'd100,   1'b1, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_COMMAND, 16'd0,     1'b0, -16'sd300, 16'sd200,  16'sd5,
        1'b1, 16'sd0,    16'sd200,  1'b1, 4'b0100},
      '{ACT_COMMAND, 16'd0,     1'b0, 16'sd300,  -16'sd200, -16'sd5,
        1'b1, 16'sd300,  -16'sd200, 1'b0, 4'b0100},
      '{ACT_SAMPLE,  16'd5000,  1'b1, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_COMMAND, 16'd0,     1'b0, -16'sd300, 16'sd0,    16'sd0,
        1'b1, -16'sd300, 16'sd0,    1'b0, 4'b0000},
      '{ACT_SAMPLE,  16'd300,   1'b0, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_SAMPLE,  16'd0,     1'b1, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_SAMPLE,  16'd1000,  1'b0, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_COMMAND, 16'd0,     1'b0, 16'sd5,    -16'sd5,   16'sd9,
        1'b1, 16'sd5,    -16'sd5,   1'b0, 4'b0100},
      '{ACT_SAMPLE,  16'hFFFF,  1'b1, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_COMMAND, 16'd0,     1'b0, -16'sd7,   16'sd7,    16'sd0,
        1'b1, -16'sd7,   16'sd7,    1'b0, 4'b0000},
      '{ACT_SAMPLE,  16'd600,   1'b0, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_SAMPLE,  16'd601,   1'b1, 16'sd0,    16'sd0,    16'sd0,
        1'b0, 16'sd0,    16'sd0,    1'b0, 4'b0000},
      '{ACT_COMMAND, 16'd0,     1'b0, 16'sd0,    16'sd0,    16'sd0,
        1'b1, 16'sd0,    16'sd0,    1'b0, 4'b0100}
    };
    program_regs(16'h8000, 16'd182, 16'd100, 16'd12000, 16'd600);
    foreach (dir_tab[i]) push_item(dir_tab[i]);

    // Reset setting again, with the long receiver hold-off.
    run_phase(16'h8000, 16'd182, 16'd100, 16'd12000, 16'd600, 1);
    // Eighth-turn steps land exactly on every sector boundary; every valid range flags.
    run_phase(16'h0000, 16'h2000, 16'h0000, 16'hFFFF, 16'hFFFF, 2);
    // Inverted window: every sample is skipped, only commands produce results.
    run_phase(16'h7FFF, 16'h8000, 16'd1000, 16'd999, 16'd2000, 0);
    // Single-unit steps across the front/left edge; only a zero range is valid.
    run_phase(16'h1FFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 0);
    // Only the largest range is valid, and it flags.
    run_phase(16'h9FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(0, 2000)),
              16'($urandom_range(3000, 65535)), 16'($urandom_range(0, 5000)), 0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(0, 2000)),
              16'($urandom_range(3000, 65535)), 16'($urandom_range(0, 5000)), 0);
    // Scan sweeping the other way.
    run_phase(16'h8000, 16'hFF4A, 16'd100, 16'd12000, 16'd600, 0);

    settle();
    if (mismatches == 0 && gate_results_q.size() == 0) begin
      $display("lidar_quadrant_collision_gate_top_tb OK");
    end else begin
      $display("lidar_quadrant_collision_gate_top_tb NOT OK");
    end
    $finish;
  end

endmodule
